// ===== src/kfat_pkg.sv =====
// kfat_pkg: shared types, codes and helpers for the keyed face arrow table.
// Used by kfat_ram, keyed_face_arrow_table_top and the sim checker and testbench. No dependencies.
package kfat_pkg;

  localparam int FACES      = 6;
  localparam int KEY_W      = 8;
  localparam int CODE_W     = 4;
  localparam int ARROWS_W   = FACES * CODE_W;
  localparam int FACE_W     = 3;

  localparam logic [CODE_W-1:0]   NO_ARROW     = 4'hF;
  localparam logic [ARROWS_W-1:0] ALL_NO_ARROW = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_WR_ALL = 2'd0,
    KIND_WR_ONE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [ARROWS_W-1:0] arrows;
    logic [KEY_W-1:0]    key;
  } entry_t;

  function automatic logic [CODE_W-1:0] get_code(input logic [ARROWS_W-1:0] word,
                                                  input logic [FACE_W-1:0]   face);
    logic [CODE_W-1:0] code;
    code = NO_ARROW;
    for (int i = 0; i < FACES; i++) begin
      if (face == FACE_W'(i)) begin
        code = word[i*CODE_W +: CODE_W];
      end
    end
    return code;
  endfunction

  function automatic logic [ARROWS_W-1:0] set_code(input logic [ARROWS_W-1:0] word,
                                                    input logic [FACE_W-1:0]   face,
                                                    input logic [CODE_W-1:0]   code);
    logic [ARROWS_W-1:0] res;
    res = word;
    for (int i = 0; i < FACES; i++) begin
      if (face == FACE_W'(i)) begin
        res[i*CODE_W +: CODE_W] = code;
      end
    end
    return res;
  endfunction

endpackage

// ===== src/kfat_ram.sv =====
// kfat_ram: single-port-write, single-port-read entry memory, registered read.
// Depends on kfat_pkg for the entry type.
module kfat_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output kfat_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  kfat_pkg::entry_t    wr_data
);
  import kfat_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/keyed_face_arrow_table_top.sv =====
// keyed_face_arrow_table_top: associative table mapping cube IDs to six face arrow codes.
// Depends on kfat_pkg and kfat_ram.
//
// One command per transaction, one result per command. Entries live in a single
// memory with a registered read and are scanned one entry per cycle through its
// read port; a scan stops at the match or, on a miss, after the fill count of
// entries (at most CAPACITY); a clear skips the scan. A new command is accepted while
// the previous result still waits on the output. On a write with a new ID and the
// table full the command is dropped and flagged.
module keyed_face_arrow_table_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] cube_id, [10:8] face, [14:11] one_arrow, [38:15] all_arrows, [39] zero
  input  logic [39:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] arrow_out, [4] hit, [5] dropped, [7:6] zero
  output logic [7:0]  out_tdata
);
  import kfat_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = IW + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       chk_r, chk_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                hit_r, hit_nxt;
  logic [ARROWS_W-1:0] word_r, word_nxt;
  kind_t               kind_r, kind_nxt;
  logic [KEY_W-1:0]    id_r, id_nxt;
  logic [FACE_W-1:0]   face_r, face_nxt;
  logic [CODE_W-1:0]   one_r, one_nxt;
  logic [ARROWS_W-1:0] all_r, all_nxt;
  logic [CODE_W-1:0]   res_arrow_r, res_arrow_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic                res_drop_r, res_drop_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [7:0]          out_tdata_r, out_tdata_nxt;

  logic [SW-1:0]       chk_inc;
  logic [IW-1:0]       rd_addr;
  entry_t              rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;
  logic                full;
  logic [IW-1:0]       tgt_idx;
  logic [ARROWS_W-1:0] base_word;

  kfat_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign chk_inc   = SW'(chk_r) + SW'(1);
  assign rd_addr   = (state_r == ST_IDLE) ? '0 : chk_inc[IW-1:0];
  assign full      = (count_r == CW'(CAPACITY));
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    chk_nxt        = chk_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    word_nxt       = word_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    face_nxt       = face_r;
    one_nxt        = one_r;
    all_nxt        = all_r;
    res_arrow_nxt  = res_arrow_r;
    res_hit_nxt    = res_hit_r;
    res_drop_nxt   = res_drop_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    tgt_idx        = idx_r;
    base_word      = word_r;
    wr_data        = '{arrows: word_r, key: id_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = kind_t'(in_tuser);
          id_nxt   = in_tdata[7:0];
          face_nxt = in_tdata[10:8];
          one_nxt  = in_tdata[14:11];
          all_nxt  = in_tdata[38:15];
          chk_nxt  = '0;
          hit_nxt  = 1'b0;
          if (kind_t'(in_tuser) == KIND_CLEAR) begin
            count_nxt     = '0;
            res_arrow_nxt = NO_ARROW;
            res_hit_nxt   = 1'b0;
            res_drop_nxt  = 1'b0;
            state_nxt     = ST_RESP;
          end else if (count_r == '0) begin
            state_nxt = ST_UPD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_data.key == id_r) begin
          hit_nxt   = 1'b1;
          idx_nxt   = chk_r;
          word_nxt  = rd_data.arrows;
          state_nxt = ST_UPD;
        end else if (chk_inc == SW'(count_r)) begin
          state_nxt = ST_UPD;
        end else begin
          chk_nxt = chk_inc[IW-1:0];
        end
      end
      ST_UPD: begin
        res_arrow_nxt = NO_ARROW;
        res_hit_nxt   = hit_r;
        res_drop_nxt  = 1'b0;
        if (kind_r == KIND_LOOKUP) begin
          if (hit_r) begin
            res_arrow_nxt = get_code(word_r, face_r);
          end
        end else begin
          if (!hit_r) begin
            if (full) begin
              res_drop_nxt = 1'b1;
            end else begin
              tgt_idx   = count_r[IW-1:0];
              base_word = ALL_NO_ARROW;
              count_nxt = count_r + CW'(1);
            end
          end
          if (hit_r || !full) begin
            wr_en   = 1'b1;
            wr_addr = tgt_idx;
            wr_data.key    = id_r;
            wr_data.arrows = (kind_r == KIND_WR_ALL) ? all_r
                                                     : set_code(base_word, face_r, one_r);
          end
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, res_drop_r, res_hit_r, res_arrow_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r       <= chk_nxt;
    idx_r       <= idx_nxt;
    hit_r       <= hit_nxt;
    word_r      <= word_nxt;
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    face_r      <= face_nxt;
    one_r       <= one_nxt;
    all_r       <= all_nxt;
    res_arrow_r <= res_arrow_nxt;
    res_hit_r   <= res_hit_nxt;
    res_drop_r  <= res_drop_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(count_r) <= SW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (SW'(chk_r) < SW'(count_r)))
    else $error("scan pointer beyond filled entries");

  a_drop_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && res_drop_nxt) |-> (!hit_r && full && !wr_en))
    else $error("drop without full table miss");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("accepted transaction not started");

endmodule

// ===== sim/keyed_face_arrow_table_checker.sv =====
`timescale 1ns / 100ps
// keyed_face_arrow_table_checker: watches both stream channels of the arrow table, keeps its
// own copy of the key and arrow stores, and checks every result against the predicted one.
// Depends on kfat_pkg for the command codes and field widths.
module keyed_face_arrow_table_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  output int          mismatches,
  output int          awaiting
);
  import kfat_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] arrow;
    logic              hit;
    logic              dropped;
  } table_reply_t;

  logic [KEY_W-1:0]    key_mem   [DEPTH];
  logic [ARROWS_W-1:0] arrow_mem [DEPTH];
  int                  fill = 0;
  table_reply_t        reply_q [$];
  table_reply_t        want;
  int                  err_cnt = 0;

  task automatic predict_reply(input kind_t kind, input logic [KEY_W-1:0] id,
                               input logic [FACE_W-1:0] face, input logic [CODE_W-1:0] code,
                               input logic [ARROWS_W-1:0] arrows);
    table_reply_t r;
    int slot;
    r.arrow   = NO_ARROW;
    r.hit     = 1'b0;
    r.dropped = 1'b0;
    if (kind == KIND_CLEAR) begin
      fill = 0;
    end else begin
      slot = -1;
      for (int k = 0; k < fill; k++) begin
        if (slot < 0 && key_mem[k] == id) slot = k;
      end
      r.hit = (slot >= 0);
      if (kind == KIND_LOOKUP) begin
        if (slot >= 0 && face < FACES) r.arrow = arrow_mem[slot][face*CODE_W +: CODE_W];
      end else begin
        if (slot < 0) begin
          if (fill >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            slot            = fill;
            key_mem[slot]   = id;
            arrow_mem[slot] = ALL_NO_ARROW;
            fill++;
          end
        end
        if (!r.dropped) begin
          if (kind == KIND_WR_ALL) arrow_mem[slot] = arrows;
          else if (face < FACES) arrow_mem[slot][face*CODE_W +: CODE_W] = code;
        end
      end
    end
    reply_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      reply_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_reply(kind_t'(in_tuser), in_tdata[7:0], in_tdata[10:8], in_tdata[14:11],
                      in_tdata[38:15]);
      end
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          $display("%0t unexpected result transaction: got %h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (out_tdata[3:0] !== want.arrow) begin
            $display("%0t arrow_out mismatch: expected %h, got %h", $time, want.arrow,
                     out_tdata[3:0]);
            err_cnt++;
          end
          if (out_tdata[4] !== want.hit) begin
            $display("%0t hit mismatch: expected %b, got %b", $time, want.hit, out_tdata[4]);
            err_cnt++;
          end
          if (out_tdata[5] !== want.dropped) begin
            $display("%0t dropped mismatch: expected %b, got %b", $time, want.dropped,
                     out_tdata[5]);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    awaiting   <= reply_q.size();
  end

endmodule

// ===== sim/keyed_face_arrow_table_top_tb.sv =====
`timescale 1ns / 100ps
// keyed_face_arrow_table_top_tb: stimulus and verdict for the cube arrow table.
// Depends on kfat_pkg, keyed_face_arrow_table_top and keyed_face_arrow_table_checker.
module keyed_face_arrow_table_top_tb;
  import kfat_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_N      = 22;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  int   mismatches;
  int   awaiting;
  int   send_idle  = 0;
  int   recv_stall = 0;
  logic hold_rx    = 1'b0;

  logic [KEY_W-1:0] id_pool [POOL_N];
  int idle_tab  [4] = '{0, 88, 0, 38};
  int stall_tab [4] = '{0, 0, 88, 38};

  keyed_face_arrow_table_top #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  keyed_face_arrow_table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_rx) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_cmd(input kind_t kind, input logic [KEY_W-1:0] id,
                          input logic [FACE_W-1:0] face, input logic [CODE_W-1:0] code,
                          input logic [ARROWS_W-1:0] arrows);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, arrows, code, face, id};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random();
    int pick;
    kind_t kind;
    logic [KEY_W-1:0] id;
    logic [FACE_W-1:0] face;
    pick = $urandom_range(99);
    if (pick < 2) kind = KIND_CLEAR;
    else if (pick < 30) kind = KIND_WR_ALL;
    else if (pick < 58) kind = KIND_WR_ONE;
    else kind = KIND_LOOKUP;
    id   = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_N-1)]
                                     : KEY_W'($urandom_range(255));
    face = ($urandom_range(99) < 80) ? FACE_W'($urandom_range(FACES-1))
                                     : FACE_W'($urandom_range(7));
    send_cmd(kind, id, face, CODE_W'($urandom_range(15)), ARROWS_W'($urandom));
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_N; i++) id_pool[i] = KEY_W'($urandom_range(255));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, key and code extremes, bad faces, full table, clear
    send_cmd(KIND_LOOKUP, 8'd0, 3'd0, 4'h0, 24'h0);
    send_cmd(KIND_WR_ALL, 8'd0, 3'd0, 4'h0, 24'h000000);
    send_cmd(KIND_WR_ALL, 8'd255, 3'd7, 4'hF, 24'hFFFFFF);
    send_cmd(KIND_LOOKUP, 8'd255, 3'd5, 4'h0, 24'h0);
    send_cmd(KIND_WR_ONE, 8'd0, 3'd5, 4'h7, 24'h0);
    send_cmd(KIND_WR_ONE, 8'd0, 3'd0, 4'h8, 24'hFFFFFF);
    send_cmd(KIND_WR_ONE, 8'd17, 3'd7, 4'h3, 24'h0);
    send_cmd(KIND_LOOKUP, 8'd17, 3'd6, 4'h0, 24'h0);
    send_cmd(KIND_LOOKUP, 8'd0, 3'd5, 4'h0, 24'h0);
    send_cmd(KIND_WR_ALL, 8'd0, 3'd0, 4'h0, 24'hA5C3E1);
    for (int i = 0; i < TABLE_DEPTH - 3; i++) begin
      send_cmd(KIND_WR_ONE, 8'(100 + i), 3'(i % FACES), 4'(i), 24'h0);
    end
    send_cmd(KIND_WR_ALL, 8'd200, 3'd0, 4'h0, 24'h123456);
    send_cmd(KIND_WR_ONE, 8'd201, 3'd2, 4'h1, 24'h0);
    send_cmd(KIND_LOOKUP, 8'd112, 3'd0, 4'h0, 24'h0);
    send_cmd(KIND_CLEAR, 8'd0, 3'd0, 4'h0, 24'h0);
    send_cmd(KIND_LOOKUP, 8'd0, 3'd0, 4'h0, 24'h0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      refill_pool();
      send_idle  = idle_tab[ph];
      recv_stall <= stall_tab[ph];
      repeat (180) send_random();
      if (ph == 1) begin
        send_idle  = 0;
        recv_stall <= 0;
        fork
          begin
            hold_rx <= 1'b1;
            repeat (300) @(posedge clk);
            hold_rx <= 1'b0;
          end
          repeat (40) send_random();
        join
        drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
